### src/asc_pkg.sv
`timescale 1ns / 1ps
package asc_pkg;

   localparam int RoundsPerCycle = 1;

   localparam logic [63:0] EngineIv = 64'h00001000808c0001;
   localparam logic [63:0] DomainBit = 64'h8000000000000000;

   localparam logic [1:0] CMD_INIT = 2'd0;
   localparam logic [1:0] CMD_AD = 2'd1;
   localparam logic [1:0] CMD_TEXT = 2'd2;
   localparam logic [1:0] CMD_FINAL = 2'd3;

   localparam logic [1:0] REG_KEY_LO = 2'd0;
   localparam logic [1:0] REG_KEY_HI = 2'd1;
   localparam logic [1:0] REG_MODE = 2'd2;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_FRESH = 2'd1;
   localparam logic [1:0] PH_OPEN = 2'd2;
   localparam logic [1:0] PH_CLOSED = 2'd3;

   // operation codes of a job for the back end
   localparam logic [2:0] OP_INIT = 3'd0;
   localparam logic [2:0] OP_AD = 3'd1;
   localparam logic [2:0] OP_TEXT = 3'd3;
   localparam logic [2:0] OP_FINAL = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic        close_ad;   // pad empty ad block and run 8 rounds first
      logic        sep;        // apply domain separation first
      logic        pad_text;   // finalize: pad an open text block first
      logic        decrypt;
      logic [4:0]  n;
      logic [63:0] lo;
      logic [63:0] hi;
   } job_type;

   typedef logic [4:0][63:0] state_type;

   function automatic logic [7:0] round_const(input logic [3:0] r);
      logic [7:0] c;
      c = 8'hf0 - {r, 4'h0} + {4'h0, r};
      return c;
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic state_type one_round(input state_type s, input logic [3:0] r);
      state_type x;
      logic [63:0] a0, a1, a2, a3, a4;
      x = s;
      x[2] = x[2] ^ {56'h0, round_const(r)};
      x[0] = x[0] ^ x[4];
      x[4] = x[4] ^ x[3];
      x[2] = x[2] ^ x[1];
      a0 = x[0] ^ (~x[1] & x[2]);
      a1 = x[1] ^ (~x[2] & x[3]);
      a2 = x[2] ^ (~x[3] & x[4]);
      a3 = x[3] ^ (~x[4] & x[0]);
      a4 = x[4] ^ (~x[0] & x[1]);
      a1 = a1 ^ a0;
      a0 = a0 ^ a4;
      a3 = a3 ^ a2;
      a2 = ~a2;
      x[0] = a0 ^ rotr(a0, 19) ^ rotr(a0, 28);
      x[1] = a1 ^ rotr(a1, 61) ^ rotr(a1, 39);
      x[2] = a2 ^ rotr(a2, 1) ^ rotr(a2, 6);
      x[3] = a3 ^ rotr(a3, 10) ^ rotr(a3, 17);
      x[4] = a4 ^ rotr(a4, 7) ^ rotr(a4, 41);
      return x;
   endfunction

   function automatic logic [63:0] byte_mask(input logic [4:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (5'(i) < n) m[i*8 +: 8] = 8'hff;
      end
      return m;
   endfunction

   function automatic logic [63:0] pad_word(input logic [4:0] n);
      logic [63:0] p;
      p = '0;
      p[{n[2:0], 3'b000}] = 1'b1;
      return p;
   endfunction

endpackage

### src/asc_front.sv
`timescale 1ns / 1ps
module asc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [135:0]         req_tdata,
   input  logic [1:0]           req_tuser,
   input  logic                 mode,
   output logic                 job_valid,
   input  logic                 job_ready,
   output asc_pkg::job_type     job
);

   logic [1:0] phase_ff, phase_in;
   logic       sep_ff, sep_in;
   logic [1:0] cmd;
   logic [4:0] n;
   logic       emit;
   asc_pkg::job_type j;

   assign cmd = req_tuser;
   assign n = (req_tdata[132:128] > 5'd16) ? 5'd16 : req_tdata[132:128];
   assign req_tready = job_ready;

   always_comb begin
      phase_in = phase_ff;
      sep_in = sep_ff;
      emit = 1'b0;
      j = '0;
      j.lo = req_tdata[63:0];
      j.hi = req_tdata[127:64];
      j.n = n;
      j.decrypt = mode;
      unique case (cmd)
         asc_pkg::CMD_INIT: begin
            emit = 1'b1;
            j.op = asc_pkg::OP_INIT;
            phase_in = asc_pkg::PH_FRESH;
            sep_in = 1'b0;
         end
         asc_pkg::CMD_AD: begin
            if (phase_ff != asc_pkg::PH_IDLE && !sep_ff
                && phase_ff != asc_pkg::PH_CLOSED) begin
               if (n == 5'd0 && phase_ff == asc_pkg::PH_FRESH) begin
                  phase_in = asc_pkg::PH_CLOSED;
               end else begin
                  emit = 1'b1;
                  j.op = asc_pkg::OP_AD;
                  phase_in = (n < 5'd16) ? asc_pkg::PH_CLOSED : asc_pkg::PH_OPEN;
               end
            end
         end
         asc_pkg::CMD_TEXT: begin
            if (phase_ff != asc_pkg::PH_IDLE
                && !(sep_ff && phase_ff == asc_pkg::PH_CLOSED)) begin
               emit = 1'b1;
               j.op = asc_pkg::OP_TEXT;
               j.sep = !sep_ff;
               j.close_ad = !sep_ff && phase_ff == asc_pkg::PH_OPEN;
               sep_in = 1'b1;
               phase_in = (n < 5'd16) ? asc_pkg::PH_CLOSED : asc_pkg::PH_OPEN;
            end
         end
         default: begin
            if (phase_ff != asc_pkg::PH_IDLE) begin
               emit = 1'b1;
               j.op = asc_pkg::OP_FINAL;
               j.sep = !sep_ff;
               j.close_ad = !sep_ff && phase_ff == asc_pkg::PH_OPEN;
               j.pad_text = !sep_ff || phase_ff == asc_pkg::PH_OPEN;
               sep_in = 1'b0;
               phase_in = asc_pkg::PH_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= asc_pkg::PH_IDLE;
         sep_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         phase_ff <= phase_in;
         sep_ff <= sep_in;
      end
   end

   assign job_valid = req_tvalid && emit;
   assign job = j;

   a_sep_phase: assert property (@(posedge clock) disable iff (reset)
      sep_ff |-> (phase_ff == asc_pkg::PH_OPEN || phase_ff == asc_pkg::PH_CLOSED))
      else $error("separation outside text phase");
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == asc_pkg::PH_IDLE |-> !sep_ff)
      else $error("separation flag set while idle");
   a_init_fresh: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && cmd == asc_pkg::CMD_INIT
      |=> phase_ff == asc_pkg::PH_FRESH && !sep_ff)
      else $error("init did not restart phase");

endmodule

### src/asc_queue.sv
`timescale 1ns / 1ps
module asc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  asc_pkg::job_type     in_job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output asc_pkg::job_type     out_job
);

   asc_pkg::job_type slot_ff [2];
   logic [1:0] cnt_ff;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= in_job;
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff)
      else $error("queue pointers out of step");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count missed a push");

endmodule

### src/asc_core.sv
`timescale 1ns / 1ps
module asc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  asc_pkg::job_type     job,
   input  logic [63:0]          key_lo,
   input  logic [63:0]          key_hi,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [135:0]         rsp_tdata,
   output logic [1:0]           rsp_tuser
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CLOSE = 3'd1;   // rounds of empty ad block, then text absorb or tag setup
   localparam logic [2:0] S_MAIN = 3'd2;    // rounds of ad, text or init
   localparam logic [2:0] S_FIN = 3'd3;     // tag rounds

   logic [2:0]  st_ff, st_in;
   asc_pkg::state_type x_ff, x_in, xr, xs;
   logic [3:0]  r_ff, r_in;
   asc_pkg::job_type j_ff, j_in;
   logic        ov_ff, ov_in;
   logic [135:0] od_ff, od_in;
   logic [1:0]  ou_ff, ou_in;
   logic        out_free;
   logic [63:0] mlo, mhi, c0, c1;
   logic        last;

   assign out_free = !ov_ff || rsp_tready;
   assign job_ready = st_ff == S_IDLE && out_free;

   always_comb begin
      xr = x_ff;
      for (int k = 0; k < asc_pkg::RoundsPerCycle; k++) begin
         if (r_ff + 4'(k) < 4'd12) xr = asc_pkg::one_round(xr, r_ff + 4'(k));
      end
   end
   assign last = r_ff + 4'(asc_pkg::RoundsPerCycle) >= 4'd12;

   always_comb begin
      st_in = st_ff;
      x_in = x_ff;
      r_in = r_ff;
      j_in = j_ff;
      ov_in = ov_ff && !rsp_tready;
      od_in = od_ff;
      ou_in = ou_ff;
      xs = x_ff;
      mlo = asc_pkg::byte_mask(job.n);
      mhi = (job.n > 5'd8) ? asc_pkg::byte_mask(job.n - 5'd8) : '0;
      c0 = job.lo & mlo;
      c1 = job.hi & mhi;
      unique case (st_ff)
         S_IDLE: begin
            if (job_valid && job_ready) begin
               j_in = job;
               unique case (job.op)
                  asc_pkg::OP_INIT: begin
                     x_in = {job.hi, job.lo, key_hi, key_lo, asc_pkg::EngineIv};
                     r_in = 4'd0;
                     st_in = S_MAIN;
                  end
                  asc_pkg::OP_AD: begin
                     xs[0] = x_ff[0] ^ c0;
                     xs[1] = x_ff[1] ^ c1;
                     if (job.n < 5'd8) xs[0] = xs[0] ^ asc_pkg::pad_word(job.n);
                     else if (job.n < 5'd16) xs[1] = xs[1] ^ asc_pkg::pad_word(job.n);
                     x_in = xs;
                     r_in = 4'd4;
                     st_in = S_MAIN;
                  end
                  default: begin
                     // text and finalize: close an open ad phase first
                     if (job.close_ad) begin
                        xs[0] = x_ff[0] ^ asc_pkg::pad_word(5'd0);
                        x_in = xs;
                        r_in = 4'd4;
                        st_in = S_CLOSE;
                     end else begin
                        st_in = S_CLOSE;
                        r_in = 4'd12;
                     end
                  end
               endcase
            end
         end
         S_CLOSE: begin
            if (r_ff < 4'd12) begin
               x_in = xr;
               r_in = last ? 4'd12 : r_ff + 4'(asc_pkg::RoundsPerCycle);
            end else begin
               xs = x_ff;
               if (j_ff.sep) xs[4] = xs[4] ^ asc_pkg::DomainBit;
               mlo = asc_pkg::byte_mask(j_ff.n);
               mhi = (j_ff.n > 5'd8) ? asc_pkg::byte_mask(j_ff.n - 5'd8) : '0;
               c0 = j_ff.lo & mlo;
               c1 = j_ff.hi & mhi;
               if (j_ff.op == asc_pkg::OP_TEXT) begin
                  ov_in = 1'b1;
                  ou_in = 2'b00;
                  if (j_ff.decrypt) begin
                     od_in = {3'b0, j_ff.n, (xs[1] ^ c1) & mhi, (xs[0] ^ c0) & mlo};
                     xs[0] = (xs[0] & ~mlo) | c0;
                     xs[1] = (xs[1] & ~mhi) | c1;
                  end else begin
                     xs[0] = xs[0] ^ c0;
                     xs[1] = xs[1] ^ c1;
                     od_in = {3'b0, j_ff.n, xs[1] & mhi, xs[0] & mlo};
                  end
                  if (j_ff.n < 5'd16) begin
                     if (j_ff.n < 5'd8) xs[0] = xs[0] ^ asc_pkg::pad_word(j_ff.n);
                     else xs[1] = xs[1] ^ asc_pkg::pad_word(j_ff.n);
                     st_in = S_IDLE;
                  end else begin
                     r_in = 4'd4;
                     st_in = S_MAIN;
                  end
               end else begin
                  if (j_ff.pad_text) xs[0] = xs[0] ^ asc_pkg::pad_word(5'd0);
                  xs[2] = xs[2] ^ key_lo;
                  xs[3] = xs[3] ^ key_hi;
                  r_in = 4'd0;
                  st_in = S_FIN;
               end
               x_in = xs;
            end
         end
         S_MAIN: begin
            x_in = xr;
            r_in = r_ff + 4'(asc_pkg::RoundsPerCycle);
            if (last) begin
               r_in = 4'd0;
               st_in = S_IDLE;
               if (j_ff.op == asc_pkg::OP_INIT) begin
                  x_in[3] = xr[3] ^ key_lo;
                  x_in[4] = xr[4] ^ key_hi;
               end
            end
         end
         S_FIN: begin
            x_in = xr;
            r_in = r_ff + 4'(asc_pkg::RoundsPerCycle);
            if (last && out_free) begin
               r_in = 4'd0;
               x_in[3] = xr[3] ^ key_lo;
               x_in[4] = xr[4] ^ key_hi;
               ov_in = 1'b1;
               ou_in = 2'b01;
               if (j_ff.decrypt) begin
                  od_in = '0;
                  ou_in = {(x_in[3] == j_ff.lo) && (x_in[4] == j_ff.hi), 1'b1};
               end else begin
                  od_in = {3'b0, 5'd16, x_in[4], x_in[3]};
               end
               st_in = S_IDLE;
            end else if (last) begin
               x_in = x_ff;
               r_in = r_ff;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // a text block waiting in S_CLOSE for the output holds its state
   logic hold;
   assign hold = st_ff == S_CLOSE && r_ff >= 4'd12 && j_ff.op == asc_pkg::OP_TEXT
                 && !out_free;

   always_ff @(posedge clock) begin
      if (!hold) begin
         j_ff <= j_in;
         od_ff <= od_in;
         ou_ff <= ou_in;
      end
      if (reset) begin
         st_ff <= S_IDLE;
         r_ff <= '0;
         ov_ff <= 1'b0;
         x_ff <= '0;
      end else if (!hold) begin
         st_ff <= st_in;
         r_ff <= r_in;
         ov_ff <= ov_in;
         x_ff <= x_in;
      end else begin
         ov_ff <= ov_ff;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;
   assign rsp_tuser = ou_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result lost while stalled");
   a_rnd: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_MAIN |-> r_ff < 4'd12)
      else $error("round counter past end");
   a_take: assert property (@(posedge clock) disable iff (reset)
      job_ready |-> st_ff == S_IDLE)
      else $error("job taken while busy");

endmodule

### src/ascon_aead128_engine.sv
`timescale 1ns / 1ps
// result registered; init, data blocks and finalize run the permutation, a text block or
// finalize closes an open data phase first, and a full text block is absorbed, then permuted
// the core takes a new job only once it is idle and its output is free; the permutation runs
// one round per cycle, and a text block adds an absorb step before its rounds
// front end classifies items and drops out-of-order ones, a two-entry queue feeds the core
// reset: synchronous, active high; clears phase, queue, core state and key/mode registers
module ascon_aead128_engine (
   input  logic           clock,
   input  logic           reset,
   // request stream
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [135:0]   req_tdata,   // data_lo, data_hi, byte_count, 3 zero bits
   input  logic [1:0]     req_tuser,   // cmd
   // response stream
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [135:0]   rsp_tdata,   // out_lo, out_hi, out_bytes, 3 zero bits
   output logic [1:0]     rsp_tuser,   // out_kind, tag_ok
   // register write channel
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [1:0]     csr_index,
   input  logic [63:0]    csr_data
);

   logic [63:0] key_lo_ff, key_hi_ff;
   logic        mode_ff;
   logic        fj_valid, fj_ready, qj_valid, qj_ready;
   asc_pkg::job_type fj, qj;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_lo_ff <= '0;
         key_hi_ff <= '0;
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            asc_pkg::REG_KEY_LO: key_lo_ff <= csr_data;
            asc_pkg::REG_KEY_HI: key_hi_ff <= csr_data;
            asc_pkg::REG_MODE: mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // front end: dropped items take no queue slot
   asc_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .mode(mode_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   asc_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
      .out_valid(qj_valid), .out_ready(qj_ready), .out_job(qj)
   );

   asc_core u_core (
      .clock(clock), .reset(reset),
      .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
      .key_lo(key_lo_ff), .key_hi(key_hi_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == asc_pkg::REG_MODE |=> mode_ff == $past(csr_data[0]))
      else $error("mode write lost");
   a_drop: assert property (@(posedge clock) disable iff (reset)
      fj_valid |-> req_tvalid)
      else $error("job without request");
   a_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[132:128] <= 5'd16)
      else $error("text byte count out of range");

endmodule

### sim/ascon_aead128_engine_test.sv
`timescale 1ns / 1ps
module ascon_aead128_engine_test;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  nbytes;
      logic        kind;
      logic        ok;
   } aead_result_type;

   // bit-exact model of the engine: absorbs transfers, queues the blocks and tags they give
   class aead_scoreboard;
      aead_result_type expected_q[$];
      logic [63:0]  s[5];
      logic [1:0]   phase;
      bit           sep;
      logic [63:0]  key_lo, key_hi;
      bit           dec;
      int           errors;

      function new();
         for (int i = 0; i < 5; i++) s[i] = '0;
         phase = asc_pkg::PH_IDLE;
         sep = 0;
         key_lo = '0;
         key_hi = '0;
         dec = 0;
         errors = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask

      function void set_reg(logic [1:0] idx, logic [63:0] val);
         if (idx == asc_pkg::REG_KEY_LO) key_lo = val;
         else if (idx == asc_pkg::REG_KEY_HI) key_hi = val;
         else if (idx == asc_pkg::REG_MODE) dec = val[0];
      endfunction

      function logic [63:0] ror64(logic [63:0] x, int k);
         return (x >> k) | (x << (64 - k));
      endfunction

      function void sbox_round(int r);
         logic [63:0] a0, a1, a2, a3, a4;
         logic [7:0]  rc;
         rc = 8'hf0 - 8'(r * 15);
         s[2] ^= {56'h0, rc};
         s[0] ^= s[4];
         s[4] ^= s[3];
         s[2] ^= s[1];
         a0 = s[0] ^ (~s[1] & s[2]);
         a1 = s[1] ^ (~s[2] & s[3]);
         a2 = s[2] ^ (~s[3] & s[4]);
         a3 = s[3] ^ (~s[4] & s[0]);
         a4 = s[4] ^ (~s[0] & s[1]);
         a1 ^= a0;
         a0 ^= a4;
         a3 ^= a2;
         a2 = ~a2;
         s[0] = a0 ^ ror64(a0, 19) ^ ror64(a0, 28);
         s[1] = a1 ^ ror64(a1, 61) ^ ror64(a1, 39);
         s[2] = a2 ^ ror64(a2, 1) ^ ror64(a2, 6);
         s[3] = a3 ^ ror64(a3, 10) ^ ror64(a3, 17);
         s[4] = a4 ^ ror64(a4, 7) ^ ror64(a4, 41);
      endfunction

      function void rounds(int count);
         for (int r = 12 - count; r < 12; r++) sbox_round(r);
      endfunction

      function logic [63:0] lane_mask(int n);
         if (n >= 8) return '1;
         if (n <= 0) return '0;
         return (64'd1 << (8 * n)) - 64'd1;
      endfunction

      function void add_pad(int n);
         if (n < 8) s[0] ^= 64'd1 << (8 * n);
         else s[1] ^= 64'd1 << (8 * (n - 8));
      endfunction

      // close any open data and apply domain separation
      function void start_text();
         if (phase == asc_pkg::PH_OPEN) begin
            add_pad(0);
            rounds(8);
         end
         s[4] ^= asc_pkg::DomainBit;
         sep = 1;
         phase = asc_pkg::PH_OPEN;
      endfunction

      function void finish_state();
         if (!sep) begin
            start_text();
            add_pad(0);
         end else if (phase == asc_pkg::PH_OPEN) begin
            add_pad(0);
         end
         s[2] ^= key_lo;
         s[3] ^= key_hi;
         rounds(12);
         s[3] ^= key_lo;
         s[4] ^= key_hi;
      endfunction

      // tag that a finalize would produce right now, state left untouched
      function logic [127:0] tag_now();
         logic [63:0]  saved[5];
         logic [1:0]   ph;
         bit           sp;
         logic [127:0] t;
         saved = s;
         ph = phase;
         sp = sep;
         finish_state();
         t = {s[4], s[3]};
         s = saved;
         phase = ph;
         sep = sp;
         return t;
      endfunction

      function void note_item(logic [1:0] cmd, logic [63:0] lo, logic [63:0] hi,
                              logic [4:0] cnt);
         int           n;
         logic [63:0]  mlo, mhi, c0, c1;
         aead_result_type r;
         n = (cnt > 16) ? 16 : int'(cnt);
         mlo = lane_mask(n);
         mhi = (n > 8) ? lane_mask(n - 8) : '0;
         if (cmd == asc_pkg::CMD_INIT) begin
            s[0] = asc_pkg::EngineIv;
            s[1] = key_lo;
            s[2] = key_hi;
            s[3] = lo;
            s[4] = hi;
            rounds(12);
            s[3] ^= key_lo;
            s[4] ^= key_hi;
            phase = asc_pkg::PH_FRESH;
            sep = 0;
            return;
         end
         if (phase == asc_pkg::PH_IDLE) return;
         if (cmd == asc_pkg::CMD_AD) begin
            if (sep || phase == asc_pkg::PH_CLOSED) return;
            if (n == 0 && phase == asc_pkg::PH_FRESH) begin
               phase = asc_pkg::PH_CLOSED;
               return;
            end
            s[0] ^= lo & mlo;
            s[1] ^= hi & mhi;
            if (n < 16) add_pad(n);
            rounds(8);
            phase = (n < 16) ? asc_pkg::PH_CLOSED : asc_pkg::PH_OPEN;
            return;
         end
         if (cmd == asc_pkg::CMD_TEXT) begin
            if (sep && phase == asc_pkg::PH_CLOSED) return;
            if (!sep) start_text();
            c0 = lo & mlo;
            c1 = hi & mhi;
            if (dec) begin
               r.lo = (s[0] ^ c0) & mlo;
               r.hi = (s[1] ^ c1) & mhi;
               s[0] = (s[0] & ~mlo) | c0;
               s[1] = (s[1] & ~mhi) | c1;
            end else begin
               s[0] ^= c0;
               s[1] ^= c1;
               r.lo = s[0] & mlo;
               r.hi = s[1] & mhi;
            end
            if (n < 16) begin
               add_pad(n);
               phase = asc_pkg::PH_CLOSED;
            end else begin
               rounds(8);
            end
            r.nbytes = 5'(n);
            r.kind = 0;
            r.ok = 0;
            expected_q.push_back(r);
            return;
         end
         finish_state();
         r.kind = 1;
         if (dec) begin
            r.lo = '0;
            r.hi = '0;
            r.nbytes = 5'd0;
            r.ok = (s[3] == lo) && (s[4] == hi);
         end else begin
            r.lo = s[3];
            r.hi = s[4];
            r.nbytes = 5'd16;
            r.ok = 0;
         end
         expected_q.push_back(r);
         phase = asc_pkg::PH_IDLE;
         sep = 0;
      endfunction

      task check(logic [135:0] data, logic [1:0] user);
         aead_result_type e;
         if (expected_q.size() == 0) begin
            report("response with nothing expected");
            return;
         end
         e = expected_q.pop_front();
         if (data[63:0] !== e.lo)
            report($sformatf("out_lo %h, expected %h", data[63:0], e.lo));
         if (data[127:64] !== e.hi)
            report($sformatf("out_hi %h, expected %h", data[127:64], e.hi));
         if (data[132:128] !== e.nbytes)
            report($sformatf("out_bytes %0d, expected %0d", data[132:128], e.nbytes));
         if (user[0] !== e.kind)
            report($sformatf("out_kind %b, expected %b", user[0], e.kind));
         if (user[1] !== e.ok)
            report($sformatf("tag_ok %b, expected %b", user[1], e.ok));
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [135:0]  req_tdata = '0;   // data_lo, data_hi, byte_count, 3 zero bits
   logic [1:0]    req_tuser = '0;   // cmd
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;        // out_lo, out_hi, out_bytes, 3 zero bits
   logic [1:0]    rsp_tuser;        // out_kind, tag_ok
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [63:0]   csr_data = '0;

   aead_scoreboard sb = new();
   int gap_pct = 0;     // chance of a sender idle cycle
   int stall_pct = 0;   // chance of a receiver stall cycle
   int sent = 0;

   ascon_aead128_engine u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // response side: check each transfer, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // one request transfer; the model is updated right at acceptance so a following
   // tag lookup sees every earlier block
   task send(logic [1:0] cmd, logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {3'b000, cnt, hi, lo};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(cmd, lo, hi, cnt);
      sent++;
      // idle gaps after the transfer, valid held low meanwhile
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
   endtask

   task write_reg(logic [1:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   // wait until all blocks/tags are back, then let init or data rounds in flight finish
   task wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function logic [4:0] block_count();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) return 5'd16;
      if (pick < 9) return 5'($urandom_range(15));
      return 5'($urandom_range(31, 17));   // oversized, treated as full
   endfunction

   // well-formed messages with random content, plus some stray transfers
   task run_messages(int target);
      int           n_ad, n_txt;
      logic [127:0] tag;
      logic [4:0]   cnt;
      while (sent < target) begin
         if ($urandom_range(9) == 0) begin
            send(2'($urandom_range(3)), rnd64(), rnd64(), 5'($urandom_range(31)));
         end else begin
            send(asc_pkg::CMD_INIT, rnd64(), rnd64(), 5'($urandom_range(31)));
            n_ad = $urandom_range(3);
            n_txt = $urandom_range(4);
            for (int i = 0; i < n_ad; i++) begin
               cnt = block_count();
               send(asc_pkg::CMD_AD, rnd64(), rnd64(), cnt);
               if (cnt < 16) break;
            end
            for (int i = 0; i < n_txt; i++) begin
               cnt = block_count();
               send(asc_pkg::CMD_TEXT, rnd64(), rnd64(), cnt);
               if (cnt < 16) break;
            end
            if ($urandom_range(19) != 0) begin
               tag = sb.tag_now();
               if (!sb.dec || $urandom_range(2) == 0) tag = {rnd64(), rnd64()};
               else if ($urandom_range(3) == 0) tag[$urandom_range(127)] ^= 1'b1;
               send(asc_pkg::CMD_FINAL, tag[63:0], tag[127:64], 5'($urandom_range(31)));
            end
         end
      end
   endtask

   initial begin
      logic [127:0] tag;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: encrypt, keys at extremes
      write_reg(asc_pkg::REG_KEY_LO, '0);
      write_reg(asc_pkg::REG_KEY_HI, '1);
      write_reg(asc_pkg::REG_MODE, 64'd0);
      // nothing started yet: all dropped
      send(asc_pkg::CMD_TEXT, '1, '1, 5'd16);
      send(asc_pkg::CMD_FINAL, '1, '1, 5'd16);
      send(asc_pkg::CMD_AD, '1, '1, 5'd16);
      // empty data at start, then full, oversized and partial text blocks
      send(asc_pkg::CMD_INIT, '0, '0, 5'd0);
      send(asc_pkg::CMD_AD, '1, '1, 5'd0);
      send(asc_pkg::CMD_AD, '1, '1, 5'd16);        // late data, dropped
      send(asc_pkg::CMD_TEXT, '1, '1, 5'd16);
      send(asc_pkg::CMD_TEXT, '1, '0, 5'd31);      // oversized count
      send(asc_pkg::CMD_TEXT, rnd64(), rnd64(), 5'd15);
      send(asc_pkg::CMD_TEXT, '1, '1, 5'd1);       // late text, dropped
      send(asc_pkg::CMD_FINAL, '0, '0, 5'd0);
      // open data left by text, open text left by finalize
      send(asc_pkg::CMD_INIT, '1, '1, 5'd16);
      send(asc_pkg::CMD_AD, '1, '1, 5'd16);
      send(asc_pkg::CMD_TEXT, '1, '1, 5'd16);
      send(asc_pkg::CMD_FINAL, '0, '0, 5'd16);
      // finalize straight after init, and a restart mid-message
      send(asc_pkg::CMD_INIT, rnd64(), rnd64(), 5'd16);
      send(asc_pkg::CMD_AD, rnd64(), rnd64(), 5'd7);
      send(asc_pkg::CMD_INIT, rnd64(), rnd64(), 5'd16);
      send(asc_pkg::CMD_FINAL, '0, '0, 5'd16);
      wait_idle();

      // directed: decrypt, matching and broken tag
      write_reg(asc_pkg::REG_KEY_LO, '1);
      write_reg(asc_pkg::REG_KEY_HI, '0);
      write_reg(asc_pkg::REG_MODE, 64'd1);
      send(asc_pkg::CMD_INIT, rnd64(), rnd64(), 5'd16);
      send(asc_pkg::CMD_AD, rnd64(), rnd64(), 5'd9);
      send(asc_pkg::CMD_TEXT, rnd64(), rnd64(), 5'd16);
      send(asc_pkg::CMD_TEXT, rnd64(), rnd64(), 5'd8);
      tag = sb.tag_now();
      send(asc_pkg::CMD_FINAL, tag[63:0], tag[127:64], 5'd16);
      send(asc_pkg::CMD_INIT, rnd64(), rnd64(), 5'd16);
      tag = sb.tag_now() ^ 128'd1;
      send(asc_pkg::CMD_FINAL, tag[63:0], tag[127:64], 5'd16);
      wait_idle();

      // random phases with different idle patterns and settings
      for (int p = 0; p < 4; p++) begin
         gap_pct = (p == 1) ? 45 : (p == 3) ? 14 : 0;
         stall_pct = (p == 2) ? 45 : (p == 3) ? 14 : 0;
         write_reg(asc_pkg::REG_KEY_LO, rnd64());
         write_reg(asc_pkg::REG_KEY_HI, rnd64());
         write_reg(asc_pkg::REG_MODE, 64'(p % 2));
         run_messages(sent + 290);
         wait_idle();
      end

      if (sb.expected_q.size() != 0) sb.report("results never arrived");
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
